FILE: rtl/sshbpd_pkg.sv
// ----------------------------------------------------------------------------
// sshbpd_pkg
// Shared widths, byte kinds and status codes of the SSH packet deframer.
// ----------------------------------------------------------------------------
package sshbpd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 32;
   localparam int POS_W    = 33;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   // request tdata: data_byte
   localparam int REQ_DATA_W = 8;
   // response tdata: byte_out, status, payload_length, zero fill
   localparam int RSP_FIELDS_W = BYTE_W + STATUS_W + LEN_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd35000;
   localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] HDR_BYTES     = 33'd5;
   localparam logic [POS_W-1:0] LEN_BYTES     = 33'd4;
   localparam logic [POS_W-1:0] PAD_POS       = 33'd4;
   localparam logic [BYTE_W-1:0] MIN_PAD      = 8'd4;

   localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PADDING = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_PENDING = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BADPAD  = 3'd5;

endpackage

FILE: rtl/ssh_binary_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// ssh_binary_packet_deframer_core
// Tags each received byte of an SSH binary packet and reports final status.
// ----------------------------------------------------------------------------
// One byte per request, one response per request, one request per cycle. The
// byte is classified and the parser state updated in the cycle it is taken;
// the response sits in a single output register, refilled in the same cycle
// it drains, so a response follows in the next cycle; req_tready only drops
// while a response waits on rsp_tready. tuser on the request side marks the
// first byte of a buffer, tlast the last; the response carries the final
// status and payload length on its tlast beat. The user writes max_packet_length
// through csr_wr_en/csr_wr_data only while the block is idle; nothing enforces it.
module ssh_binary_packet_deframer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [sshbpd_pkg::LEN_W-1:0]       csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sshbpd_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] data_byte
   input  logic                               req_tuser,   // [0] buffer_start
   input  logic                               req_tlast,   // buffer_end
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] byte_out, [10:8] status, [42:11] pay_len, [47:43] zero
   output logic [sshbpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [sshbpd_pkg::KIND_W-1:0]      rsp_tuser,   // [1:0] byte_kind
   output logic                               rsp_tlast    // final_item
);
   import sshbpd_pkg::*;

   logic [LEN_W-1:0]      max_len_ff;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [STATUS_W-1:0]   fault_ff, fault_in;
   logic [LEN_W-1:0]      pay_ff, pay_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic [BYTE_W-1:0]     d;
   logic [POS_W-1:0]      p;
   logic [LEN_W-1:0]      len_base;
   logic [STATUS_W-1:0]   fault_base;
   logic [LEN_W-1:0]      pay_base;
   logic [LEN_W-1:0]      len_new;
   logic [STATUS_W-1:0]   fault_new;
   logic [LEN_W-1:0]      pay_new;
   logic [KIND_W-1:0]     kind;
   logic [STATUS_W-1:0]   status;
   logic [LEN_W-1:0]      plen;
   logic [POS_W-1:0]      pos_inc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign d          = req_tdata[BYTE_W-1:0];

   // start mark clears the parser before this byte is looked at
   assign p          = req_tuser ? '0 : pos_ff;
   assign len_base   = req_tuser ? '0 : len_ff;
   assign fault_base = req_tuser ? ST_PENDING : fault_ff;
   assign pay_base   = req_tuser ? '0 : pay_ff;

   always_comb begin
      priority if (p < HDR_BYTES) begin
         kind = KIND_HEADER;
      end else if (fault_base != ST_PENDING) begin
         kind = KIND_IGNORED;
      end else if (p < {1'b0, pay_base} + HDR_BYTES) begin
         kind = KIND_PAYLOAD;
      end else if (p <= {1'b0, len_base} + 33'd3) begin
         kind = KIND_PADDING;
      end else begin
         kind = KIND_IGNORED;
      end
   end

   always_comb begin
      len_new   = len_base;
      fault_new = fault_base;
      pay_new   = pay_base;
      if (p < LEN_BYTES) begin
         unique case (p[1:0])
            2'd0:    len_new = len_base | {d, 24'b0};
            2'd1:    len_new = len_base | {8'b0, d, 16'b0};
            2'd2:    len_new = len_base | {16'b0, d, 8'b0};
            default: len_new = len_base | {24'b0, d};
         endcase
         if (p[1:0] == 2'd3 && len_new > max_len_ff) begin
            fault_new = ST_OVER;
         end
      end else if (p == PAD_POS && fault_base == ST_PENDING) begin
         if (d < MIN_PAD || ({25'b0, d} + 33'd1) > {1'b0, len_base}) begin
            fault_new = ST_BADPAD;
         end else begin
            pay_new = len_base - 32'd1 - {24'b0, d};
         end
      end
   end

   // final status in fixed priority; count < len+4 is p < len+3
   always_comb begin
      status = ST_PENDING;
      plen   = '0;
      if (req_tlast) begin
         priority if (p < LEN_BYTES) begin
            status = ST_SHORT;
         end else if (fault_new == ST_OVER) begin
            status = ST_OVER;
         end else if (p < {1'b0, len_new} + 33'd3) begin
            status = ST_TRUNC;
         end else if (fault_new == ST_BADPAD) begin
            status = ST_BADPAD;
         end else begin
            status = ST_OK;
            plen   = pay_new;
         end
      end
   end

   assign pos_inc = (p < POS_MAX) ? p + 33'd1 : p;

   always_comb begin
      len_in   = len_ff;
      pos_in   = pos_ff;
      fault_in = fault_ff;
      pay_in   = pay_ff;
      if (accept) begin
         if (req_tlast) begin
            len_in   = '0;
            pos_in   = '0;
            fault_in = ST_PENDING;
            pay_in   = '0;
         end else begin
            len_in   = len_new;
            pos_in   = pos_inc;
            fault_in = fault_new;
            pay_in   = pay_new;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, plen, status, d};
         rsp_kind_in  = kind;
         rsp_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         len_ff       <= '0;
         pos_ff       <= '0;
         fault_ff     <= ST_PENDING;
         pay_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         fault_ff     <= fault_in;
         pay_ff       <= pay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/sshbpd_checker.sv
// ----------------------------------------------------------------------------
// sshbpd_checker
// Port-level checks of the deframer's response stream.
// ----------------------------------------------------------------------------
module sshbpd_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [sshbpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                               rsp_tlast
);
   import sshbpd_pkg::*;

   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    plen;

   assign status = rsp_tdata[BYTE_W +: STATUS_W];
   assign plen   = rsp_tdata[BYTE_W + STATUS_W +: LEN_W];

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // only the buffer's last byte carries a final status
   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (status != ST_PENDING)))
      else $error("status and final mark disagree");

   // payload length is reported only with ok status
   a_plen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != ST_OK |-> plen == '0)
      else $error("payload length without ok status");

   // every accepted request shows up as a response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

endmodule

bind ssh_binary_packet_deframer_core sshbpd_checker u_sshbpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: bench/tb_ssh_binary_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_ssh_binary_packet_deframer_core
// Self-checking bench for the SSH binary packet deframer. Buffers of bytes
// (well-formed packets, bad padding, oversized lengths, truncations and
// noise) are streamed in under random back-pressure on both sides. Every
// response is compared against a cycle-free model of the byte tagging and
// final status, across several max_packet_length settings.
// ----------------------------------------------------------------------------
module tb_ssh_binary_packet_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import sshbpd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [STATUS_W-1:0] NO_FAULT = 3'd0;

   typedef struct packed {
      logic [BYTE_W-1:0]   byte_val;
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    plen;
      logic                last;
   } byte_tag_type;

   // Tracks the parser state and holds the tags still owed by the block.
   class deframe_tracker;
      logic [LEN_W-1:0]    max_len;
      logic [LEN_W-1:0]    len_acc;
      logic [POS_W-1:0]    pos;
      logic [STATUS_W-1:0] fault;
      logic [LEN_W-1:0]    pay_cnt;
      byte_tag_type        tag_q[$];
      int                  errors;
      int                  status_seen[8];

      function new();
         max_len = MAX_LEN_RESET;
         errors  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         len_acc = '0;
         pos     = '0;
         fault   = NO_FAULT;
         pay_cnt = '0;
      endfunction

      function int pending();
         return tag_q.size();
      endfunction

      function void take_byte(logic [BYTE_W-1:0] d, logic s, logic e);
         byte_tag_type    t;
         longint unsigned p;
         longint unsigned cnt;
         int              sh;
         if (s) clear_parse();
         p = pos;
         // classify with state from earlier bytes only
         if (p < HDR_BYTES) t.kind = KIND_HEADER;
         else if (fault != NO_FAULT) t.kind = KIND_IGNORED;
         else if (p - HDR_BYTES < pay_cnt) t.kind = KIND_PAYLOAD;
         else if (p <= len_acc + 3) t.kind = KIND_PADDING;
         else t.kind = KIND_IGNORED;

         if (p < LEN_BYTES) begin
            sh = 8 * (3 - int'(p));
            len_acc = len_acc | (32'(d) << sh);
            if (p == 3 && len_acc > max_len) fault = ST_OVER;
         end else if (p == PAD_POS) begin
            if (fault == NO_FAULT) begin
               if (d < MIN_PAD || 33'(d) + 33'd1 > 33'(len_acc)) fault = ST_BADPAD;
               else pay_cnt = len_acc - 32'd1 - 32'(d);
            end
         end

         t.status = ST_PENDING;
         t.plen   = '0;
         if (e) begin
            cnt = p + 1;
            if (cnt < HDR_BYTES) t.status = ST_SHORT;
            else if (fault == ST_OVER) t.status = ST_OVER;
            else if (cnt < len_acc + 4) t.status = ST_TRUNC;
            else if (fault == ST_BADPAD) t.status = ST_BADPAD;
            else begin
               t.status = ST_OK;
               t.plen   = pay_cnt;
            end
            status_seen[t.status]++;
         end

         if (pos != POS_MAX) pos++;
         if (e) clear_parse();
         t.byte_val = d;
         t.last     = e;
         tag_q.push_back(t);
      endfunction

      function void diff(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 100)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         end
      endfunction

      function void match_tag(logic [RSP_DATA_W-1:0] td, logic [KIND_W-1:0] tu, logic tl);
         byte_tag_type t;
         if (tag_q.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending, tdata %0h", $time, td);
            return;
         end
         t = tag_q.pop_front();
         diff("byte_out", t.byte_val, td[BYTE_W-1:0]);
         diff("byte_kind", t.kind, tu);
         diff("status", t.status, td[BYTE_W +: STATUS_W]);
         diff("pay_len", t.plen, td[BYTE_W+STATUS_W +: LEN_W]);
         diff("final_item", t.last, tl);
         diff("zero fill", '0, td[RSP_DATA_W-1:RSP_FIELDS_W]);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [LEN_W-1:0]         csr_wr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata;   // [7:0] data_byte
   logic                     req_tuser;   // [0] buffer_start
   logic                     req_tlast;   // buffer_end
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // [7:0] byte_out, [10:8] status, [42:11] pay_len, [47:43] zero
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic [KIND_W-1:0]        rsp_tuser;   // [1:0] byte_kind
   logic                     rsp_tlast;   // final_item

   deframe_tracker tracker = new();

   int             sent_items = 0;
   int             cycles = 0;
   int             rsp_hold = 0;
   int             rsp_burst = 0;
   int             rsp_pick;
   bit             req_burst = 0;
   logic [7:0]     frame_bytes[$];

   ssh_binary_packet_deframer_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycles, tracker.pending());
         $display("FAILURE");
         $finish;
      end
   end

   // response back-pressure: short stalls, a few long ones, some stall-free runs
   always @(negedge clock) begin
      if (rsp_burst > 0) begin
         rsp_burst--;
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_pick = $urandom_range(0, 99);
         if (rsp_pick < 3) begin
            rsp_burst = $urandom_range(20, 80);
            rsp_tready <= 1'b1;
         end else if (rsp_pick < 22) begin
            rsp_hold = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else if (rsp_pick < 25) begin
            rsp_hold = $urandom_range(8, 30);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.match_tag(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready) tracker.take_byte(req_tdata, req_tuser, req_tlast);
         if (csr_wr_en) tracker.max_len = csr_wr_data;
      end
   end

   function automatic int req_gap();
      int r;
      r = $urandom_range(0, 99);
      if (req_burst || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_req(input logic [7:0] d, input logic s, input logic e);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= s;
      req_tlast  <= e;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic send_frame(input bit s, input bit e);
      foreach (frame_bytes[i])
         send_req(frame_bytes[i], s && i == 0, e && i == frame_bytes.size() - 1);
   endtask

   // drops valid and waits until every owed response has been taken
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_max(input logic [LEN_W-1:0] v);
      wait_drained();
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic trim_to(input int keep);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
   endtask

   task automatic pad_random(input int n);
      repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_packet();
      int          sel;
      int          pay;
      int          padn;
      int          cut;
      logic [31:0] len;
      bit          start_mark;
      bit          end_mark;
      sel        = $urandom_range(0, 99);
      start_mark = $urandom_range(0, 6) != 0;
      end_mark   = 1'b1;
      if ($urandom_range(0, 6) == 0) req_burst = !req_burst;
      if (sel < 60) begin
         // well-formed packet, sometimes cut short, padded out or left open
         padn = $urandom_range(4, 12);
         pay  = $urandom_range(0, 24);
         len  = 32'(pay + padn + 1);
         frame_bytes = '{len[31:24], len[23:16], len[15:8], len[7:0], 8'(padn)};
         pad_random(pay + padn);
         cut = $urandom_range(0, 9);
         if (cut == 0) trim_to($urandom_range(1, frame_bytes.size() - 1));
         else if (cut == 1) pad_random($urandom_range(1, 4));
         else if (cut == 2) end_mark = 1'b0;
      end else if (sel < 75) begin
         // padding below the minimum or not fitting in the length
         len  = $urandom_range(0, 20);
         padn = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(len, 255);
         frame_bytes = '{len[31:24], len[23:16], len[15:8], len[7:0], 8'(padn)};
         if (len >= 1) pad_random(len - 1);
         pad_random($urandom_range(0, 2));
      end else if (sel < 87) begin
         // arbitrary 32-bit length, mostly oversized or truncated
         len = $urandom();
         frame_bytes = '{len[31:24], len[23:16], len[15:8], len[7:0],
                         8'($urandom_range(0, 255))};
         pad_random($urandom_range(0, 6));
         if ($urandom_range(0, 3) == 0) trim_to($urandom_range(1, 4));
      end else begin
         // noise with random marks anywhere
         repeat ($urandom_range(1, 8))
            send_req(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 3) == 0);
         return;
      end
      send_frame(start_mark, end_mark);
   endtask

   initial begin
      logic [LEN_W-1:0] max_values[6];
      int               goal;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one-byte buffer, two-byte buffer, short good packet,
      // oversized length without a start mark, zero length with bad padding
      frame_bytes = '{8'h00};
      send_frame(1, 1);
      frame_bytes = '{8'hFF, 8'h7F};
      send_frame(1, 1);
      frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h06, 8'h04, 8'h5A, 8'hAA, 8'h55, 8'hFF, 8'h00};
      send_frame(1, 1);
      frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04, 8'h80};
      send_frame(0, 1);
      frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
      send_frame(1, 1);

      max_values[0] = MAX_LEN_RESET;
      max_values[1] = 32'hFFFF_FFFF;
      max_values[2] = 32'd0;
      max_values[3] = $urandom_range(6, 40);
      max_values[4] = $urandom();
      max_values[5] = MAX_LEN_RESET;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) write_max(max_values[ph]);
         goal = sent_items + 150;
         while (sent_items < goal) begin
            if ($urandom_range(0, 49) == 0) wait_drained();
            send_packet();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d bytes over 6 max_packet_length settings, 0 and all-ones included.",
               sent_items);
      $display("Buffer outcomes: ok %0d, short %0d, over max %0d, truncated %0d, bad pad %0d",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_SHORT],
               tracker.status_seen[ST_OVER], tracker.status_seen[ST_TRUNC],
               tracker.status_seen[ST_BADPAD]);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: ssh_binary_packet_deframer_core.f
rtl/sshbpd_pkg.sv
rtl/ssh_binary_packet_deframer_core.sv
rtl/sshbpd_checker.sv
bench/tb_ssh_binary_packet_deframer_core.sv
